>>> design/tcw_pkg.sv
// Shared types, constants and helpers for the text console cursor writer.
// Used by text_console_cursor_writer_core, which instantiates tcw_ram.
// No dependencies.
package tcw_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int OP_W   = 3;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR    = 3'd0,
        OP_PUT_AT      = 3'd1,
        OP_BACKSPACE   = 3'd2,
        OP_CLEAR       = 3'd3,
        OP_CLEAR_LINE  = 3'd4,
        OP_SET_CURSOR  = 3'd5,
        OP_READ        = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_READ,
        ACT_FILL,
        ACT_SCROLL
    } act_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  target_row;
        logic [COL_W-1:0]  target_col;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
        logic              out_of_range;
    } result_t;

    // Linear store address of a screen position.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

>>> design/text_console_cursor_writer_core.sv
// Text console cursor writer: ROWS x COLS screen store plus a cursor; uses tcw_pkg, tcw_ram.
// An item is taken only in IDLE: the next item waits until the previous one is finished and
// its result word has gone into the output register.
// Reset: cursor homes, attribute goes to 0x0F, then a pass over the whole store blanks it
// while item_stall stays high.
module text_console_cursor_writer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // item channel
    input  logic                           item_valid,
    output logic                           item_stall,
    input  tcw_pkg::item_t                 item,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output tcw_pkg::result_t               result,
    // attribute register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);

    localparam int AW = tcw_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tcw_pkg::state_t                 state_reg, state_next;
    tcw_pkg::item_t                  item_reg;
    logic [tcw_pkg::ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [tcw_pkg::ATTR_W-1:0]      attr_reg;
    logic [AW-1:0]                   sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]                   sweep_end_reg, sweep_end_next;
    logic                            copy_pend_reg, copy_pend_next;
    logic [AW-1:0]                   copy_addr_reg, copy_addr_next;
    tcw_pkg::result_t                pend_reg, pend_next;
    logic                            result_valid_reg, result_valid_next;
    tcw_pkg::result_t                result_reg, result_next;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                            item_take;
    logic                            out_free;
    logic                            sweep_last;
    logic                            scroll_last;
    logic                            fill_last;

    logic                            row_ok;
    logic                            col_ok;
    logic [AW-1:0]                   cur_addr;
    logic [AW-1:0]                   tgt_addr;
    logic [AW-1:0]                   row_addr;

    tcw_pkg::act_t                   ex_act;
    logic [tcw_pkg::ROW_W-1:0]       ex_row;
    logic [tcw_pkg::COL_W-1:0]       ex_col;
    logic                            ex_oor;
    logic                            ex_we;
    logic [AW-1:0]                   ex_waddr;
    logic [tcw_pkg::CELL_W-1:0]      ex_wdata;
    logic                            ex_re;
    logic [AW-1:0]                   ex_fill_start;
    logic [AW-1:0]                   ex_fill_end;
    tcw_pkg::result_t                ex_res;

    logic                            fin;
    tcw_pkg::result_t                fin_res;

    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_rdata;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Items are taken only in IDLE; the output register lets a new item in
    // while the previous result word still waits downstream.
    assign item_stall   = (state_reg != tcw_pkg::ST_IDLE);
    assign item_take    = item_valid && (state_reg == tcw_pkg::ST_IDLE);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // ------------------------------------------------------------------
    // Screen store
    // ------------------------------------------------------------------
    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::DEPTH)
    ) u_screen (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Address arithmetic for the held item
    // ------------------------------------------------------------------
    // Compare one bit wider so that ROWS = 32 or COLS = 128 still work.
    assign row_ok   = {1'b0, item_reg.target_row} < (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS);
    assign col_ok   = {1'b0, item_reg.target_col} < (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS);
    assign cur_addr = tcw_pkg::cell_addr(cur_row_reg, cur_col_reg);
    assign tgt_addr = tcw_pkg::cell_addr(item_reg.target_row, item_reg.target_col);
    assign row_addr = tcw_pkg::cell_addr(item_reg.target_row, '0);

    assign sweep_last  = (sweep_addr_reg == AW'(tcw_pkg::DEPTH - 1));
    assign scroll_last = sweep_last;
    // A copy write left over from the scroll phase holds the fill back.
    assign fill_last   = !copy_pend_reg && (sweep_addr_reg == sweep_end_reg);

    // ------------------------------------------------------------------
    // Operation decode: cursor update, single-cell access, follow-up action
    // ------------------------------------------------------------------
    always_comb
    begin
        ex_act        = tcw_pkg::ACT_DONE;
        ex_row        = cur_row_reg;
        ex_col        = cur_col_reg;
        ex_oor        = 1'b0;
        ex_we         = 1'b0;
        ex_waddr      = cur_addr;
        ex_wdata      = {attr_reg, item_reg.char_code};
        ex_re         = 1'b0;
        ex_fill_start = '0;
        ex_fill_end   = AW'(tcw_pkg::DEPTH - 1);

        unique case (item_reg.operation)
            tcw_pkg::OP_PUT_CHAR:
            begin
                // Write unless newline; both end of line and newline move to next row, or scroll on the last row.
                if (item_reg.char_code != tcw_pkg::NEWLINE_CODE)
                begin
                    ex_we = 1'b1;
                end
                if (item_reg.char_code == tcw_pkg::NEWLINE_CODE ||
                    cur_col_reg == tcw_pkg::COL_W'(tcw_pkg::COLS - 1))
                begin
                    ex_col = '0;
                    if (cur_row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
                    begin
                        ex_act = tcw_pkg::ACT_SCROLL;
                    end
                    else
                    begin
                        ex_row = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    ex_col = cur_col_reg + 1'b1;
                end
            end
            tcw_pkg::OP_PUT_AT:
            begin
                if (row_ok && col_ok)
                begin
                    ex_we    = 1'b1;
                    ex_waddr = tgt_addr;
                end
                else
                begin
                    ex_oor = 1'b1;
                end
            end
            tcw_pkg::OP_BACKSPACE:
            begin
                // The previous position is always one address lower.
                if (cur_row_reg != '0 || cur_col_reg != '0)
                begin
                    ex_we    = 1'b1;
                    ex_waddr = cur_addr - AW'(1);
                    ex_wdata = {attr_reg, tcw_pkg::SPACE_CODE};
                    if (cur_col_reg == '0)
                    begin
                        ex_row = cur_row_reg - 1'b1;
                        ex_col = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
                    end
                    else
                    begin
                        ex_col = cur_col_reg - 1'b1;
                    end
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                ex_act = tcw_pkg::ACT_FILL;
                ex_row = '0;
                ex_col = '0;
            end
            tcw_pkg::OP_CLEAR_LINE:
            begin
                if (row_ok)
                begin
                    ex_act        = tcw_pkg::ACT_FILL;
                    ex_fill_start = row_addr;
                    ex_fill_end   = row_addr + AW'(tcw_pkg::COLS - 1);
                end
                else
                begin
                    ex_oor = 1'b1;
                end
            end
            tcw_pkg::OP_SET_CURSOR:
            begin
                if (row_ok)
                begin
                    ex_row = item_reg.target_row;
                end
                if (col_ok)
                begin
                    ex_col = item_reg.target_col;
                end
                ex_oor = !(row_ok && col_ok);
            end
            tcw_pkg::OP_READ:
            begin
                if (row_ok && col_ok)
                begin
                    ex_re  = 1'b1;
                    ex_act = tcw_pkg::ACT_READ;
                end
                else
                begin
                    ex_oor = 1'b1;
                end
            end
            default:
            begin
                ex_act = tcw_pkg::ACT_DONE;
            end
        endcase

        ex_res.cursor_row   = ex_row;
        ex_res.cursor_col   = ex_col;
        ex_res.cell_value   = '0;
        ex_res.out_of_range = ex_oor;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (item_take)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                unique case (ex_act)
                    tcw_pkg::ACT_DONE:
                    begin
                        state_next = out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
                    end
                    tcw_pkg::ACT_READ:   state_next = tcw_pkg::ST_READ_WAIT;
                    tcw_pkg::ACT_FILL:   state_next = tcw_pkg::ST_FILL;
                    tcw_pkg::ACT_SCROLL: state_next = tcw_pkg::ST_SCROLL;
                    default:             state_next = tcw_pkg::ST_DONE;
                endcase
            end
            tcw_pkg::ST_READ_WAIT:
            begin
                state_next = out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (scroll_last)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: memory port, sweep counter, cursor, result words
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we            = 1'b0;
        mem_waddr         = ex_waddr;
        mem_wdata         = ex_wdata;
        mem_re            = 1'b0;
        mem_raddr         = tgt_addr;
        sweep_addr_next   = sweep_addr_reg;
        sweep_end_next    = sweep_end_reg;
        copy_pend_next    = 1'b0;
        copy_addr_next    = copy_addr_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        pend_next         = pend_reg;
        fin               = 1'b0;
        fin_res           = pend_reg;

        // A pending scroll copy owns the write port.
        if (copy_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = mem_rdata;
        end

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                // Blank with the reset attribute, whatever config says meanwhile.
                mem_we          = 1'b1;
                mem_waddr       = sweep_addr_reg;
                mem_wdata       = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
                sweep_addr_next = sweep_addr_reg + AW'(1);
            end
            tcw_pkg::ST_IDLE:
            begin
                fin = 1'b0;
            end
            tcw_pkg::ST_EXEC:
            begin
                mem_we       = ex_we;
                mem_re       = ex_re;
                cur_row_next = ex_row;
                cur_col_next = ex_col;
                pend_next    = ex_res;
                if (ex_act == tcw_pkg::ACT_FILL)
                begin
                    sweep_addr_next = ex_fill_start;
                    sweep_end_next  = ex_fill_end;
                end
                else if (ex_act == tcw_pkg::ACT_SCROLL)
                begin
                    sweep_addr_next = AW'(tcw_pkg::COLS);
                end
                if (ex_act == tcw_pkg::ACT_DONE)
                begin
                    fin     = 1'b1;
                    fin_res = ex_res;
                end
            end
            tcw_pkg::ST_READ_WAIT:
            begin
                fin                = 1'b1;
                fin_res.cell_value = mem_rdata;
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Read row y, write it to row y-1 next cycle.
                mem_re          = 1'b1;
                mem_raddr       = sweep_addr_reg;
                copy_pend_next  = 1'b1;
                copy_addr_next  = sweep_addr_reg - AW'(tcw_pkg::COLS);
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (scroll_last)
                begin
                    sweep_addr_next = AW'(tcw_pkg::DEPTH - tcw_pkg::COLS);
                    sweep_end_next  = AW'(tcw_pkg::DEPTH - 1);
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (!copy_pend_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = sweep_addr_reg;
                    mem_wdata       = {attr_reg, tcw_pkg::SPACE_CODE};
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
                fin = fill_last;
            end
            tcw_pkg::ST_DONE:
            begin
                fin = 1'b1;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        // Hand the result to the output register, or hold it until there is room.
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (fin)
        begin
            if (out_free)
            begin
                result_next       = fin_res;
                result_valid_next = 1'b1;
            end
            else
            begin
                pend_next = fin_res;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcw_pkg::ST_INIT;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            attr_reg         <= tcw_pkg::RESET_ATTR;
            sweep_addr_reg   <= '0;
            sweep_end_reg    <= '0;
            copy_pend_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_end_reg    <= sweep_end_next;
            copy_pend_reg    <= copy_pend_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        copy_addr_reg <= copy_addr_next;
        pend_reg      <= pend_next;
        result_reg    <= result_next;
    end

endmodule

>>> design/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
